### hw/rtl/assert_macros.svh
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hw/rtl/fvn_pkg.sv
// types and constants of the fractal value noise texel generator
package fvn_pkg;

	typedef struct packed {
		logic [11:0] pixel_x;
		logic [11:0] pixel_y;
	} pixel_t;

	typedef struct packed {
		logic [7:0]  red;
		logic [7:0]  green;
		logic [7:0]  blue;
		logic [15:0] noise_level;
	} texel_t;

	localparam int CFG_IDX_W = 3;
	localparam int OCTAVES   = 4;

	localparam logic [CFG_IDX_W-1:0] REG_SIZE_LOG2  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_NOISE_SEED = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_COLOR_LOW  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_COLOR_HIGH = 3'd3;

	localparam logic [31:0] HASH_X   = 32'h9E3779B1;
	localparam logic [31:0] HASH_Y   = 32'h85EBCA6B;
	localparam logic [31:0] HASH_MIX = 32'h2545F491;

	localparam logic [3:0]  SIZE_RESET  = 4'd8;
	localparam logic [23:0] COLOR_WHITE = 24'hFFFFFF;

	// 3*4096 for the smoothstep weight
	localparam logic [13:0] SMOOTH_K = 14'd12288;

endpackage

### hw/rtl/fractal_value_noise_texel.sv
// top level of the fractal value noise texel generator
// One texel request is taken every clock cycle and its colour comes out on
// texel, marked by done for one cycle. busy never rises: the ten-stage
// pipeline always advances, each stage holding at most one 32x32
// multiply on any path. Configuration writes are taken at once and must only be made
// while no request is in flight.
module fractal_value_noise_texel #(
	parameter int MAX_SIZE_LOG2 = 12
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	output logic                     busy,
	input  fvn_pkg::pixel_t          pixel,
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic [fvn_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]              cfg_data,
	output logic                     done,
	output fvn_pkg::texel_t          texel
);
	import fvn_pkg::*;
	`include "assert_macros.svh"

	localparam int LATENCY = 10;

	logic [3:0]  size_q;
	logic [31:0] seed_q;
	logic [23:0] clo_q;
	logic [23:0] chi_q;

	logic [9:1] vld;

	logic [31:0] ix_s1 [OCTAVES];
	logic [31:0] iy_s1 [OCTAVES];
	logic [11:0] fx_s1 [OCTAVES];
	logic [11:0] fy_s1 [OCTAVES];

	logic [31:0] ax_s2 [OCTAVES];
	logic [31:0] ay_s2 [OCTAVES];
	logic [23:0] fxx_s2 [OCTAVES];
	logic [23:0] fyy_s2 [OCTAVES];
	logic [11:0] fx_s2 [OCTAVES];
	logic [11:0] fy_s2 [OCTAVES];

	logic [31:0] h_s3 [OCTAVES][4];
	logic [15:0] wx_s3 [OCTAVES];
	logic [15:0] wy_s3 [OCTAVES];

	logic [31:0] m_s4 [OCTAVES][4];
	logic [15:0] wx_s4 [OCTAVES];
	logic [15:0] wy_s4 [OCTAVES];

	logic [23:0] n00_s5 [OCTAVES];
	logic [23:0] n01_s5 [OCTAVES];
	logic signed [41:0] pt_s5 [OCTAVES];
	logic signed [41:0] pb_s5 [OCTAVES];
	logic [15:0] wy_s5 [OCTAVES];

	logic [23:0] top_s6 [OCTAVES];
	logic [23:0] bot_s6 [OCTAVES];
	logic [15:0] wy_s6 [OCTAVES];

	logic [23:0] top_s7 [OCTAVES];
	logic signed [41:0] p2_s7 [OCTAVES];

	logic [23:0] v_s8 [OCTAVES];

	logic [15:0] level_s9;

	logic        accept;
	logic [4:0]  s_eff;
	logic [31:0] ix_c [OCTAVES];
	logic [31:0] iy_c [OCTAVES];
	logic [11:0] fx_c [OCTAVES];
	logic [11:0] fy_c [OCTAVES];

	function automatic logic [7:0] mix8(input logic [7:0] lo, input logic [7:0] hi,
			input logic [15:0] lvl);
		logic [25:0] acc;
		acc = {18'b0, lo} * (26'h10000 - {10'b0, lvl}) + {18'b0, hi} * {10'b0, lvl}
			+ 26'h8000;
		return acc[23:16];
	endfunction

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;
	assign accept    = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q <= SIZE_RESET;
			seed_q <= '0;
			clo_q  <= '0;
			chi_q  <= COLOR_WHITE;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_SIZE_LOG2:  size_q <= cfg_data[3:0];
				REG_NOISE_SEED: seed_q <= cfg_data;
				REG_COLOR_LOW:  clo_q  <= cfg_data[23:0];
				REG_COLOR_HIGH: chi_q  <= cfg_data[23:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld  <= '0;
			done <= 1'b0;
		end else begin
			vld  <= {vld[8:1], accept};
			done <= vld[9];
		end
	end

	// lattice position per octave
	assign s_eff = (int'(size_q) > MAX_SIZE_LOG2) ? 5'(MAX_SIZE_LOG2) : {1'b0, size_q};

	always_comb begin
		int sh;
		logic [29:0] xw;
		logic [29:0] yw;
		for (int k = 0; k < OCTAVES; k++) begin
			sh = 15 + k - int'(s_eff);
			if (sh >= 0) begin
				xw = {18'b0, pixel.pixel_x} << sh;
				yw = {18'b0, pixel.pixel_y} << sh;
			end else begin
				xw = {18'b0, pixel.pixel_x} >> (-sh);
				yw = {18'b0, pixel.pixel_y} >> (-sh);
			end
			ix_c[k] = {14'b0, xw[29:12]};
			iy_c[k] = {14'b0, yw[29:12]};
			fx_c[k] = xw[11:0];
			fy_c[k] = yw[11:0];
		end
	end

	always_ff @(posedge clk) begin
		logic [31:0] ax1;
		logic [31:0] ay1;
		logic [31:0] sk;
		logic [31:0] hc;
		logic [37:0] wpx;
		logic [37:0] wpy;
		logic [31:0] mc;
		logic [23:0] nc [4];
		logic [23:0] dt;
		logic [25:0] sum;
		for (int k = 0; k < OCTAVES; k++) begin
			ix_s1[k] <= ix_c[k];
			iy_s1[k] <= iy_c[k];
			fx_s1[k] <= fx_c[k];
			fy_s1[k] <= fy_c[k];

			ax_s2[k]  <= ix_s1[k] * HASH_X;
			ay_s2[k]  <= iy_s1[k] * HASH_Y;
			fxx_s2[k] <= fx_s1[k] * fx_s1[k];
			fyy_s2[k] <= fy_s1[k] * fy_s1[k];
			fx_s2[k]  <= fx_s1[k];
			fy_s2[k]  <= fy_s1[k];

			ax1 = ax_s2[k] + HASH_X;
			ay1 = ay_s2[k] + HASH_Y;
			sk  = seed_q + 32'(k);
			for (int c = 0; c < 4; c++) begin
				hc = sk ^ (c[0] ? ax1 : ax_s2[k]) ^ (c[1] ? ay1 : ay_s2[k]);
				h_s3[k][c] <= hc ^ (hc >> 15);
			end
			wpx = fxx_s2[k] * (SMOOTH_K - {1'b0, fx_s2[k], 1'b0});
			wpy = fyy_s2[k] * (SMOOTH_K - {1'b0, fy_s2[k], 1'b0});
			wx_s3[k] <= wpx[35:20];
			wy_s3[k] <= wpy[35:20];

			for (int c = 0; c < 4; c++) begin
				m_s4[k][c] <= h_s3[k][c] * HASH_MIX;
			end
			wx_s4[k] <= wx_s3[k];
			wy_s4[k] <= wy_s3[k];

			for (int c = 0; c < 4; c++) begin
				mc = m_s4[k][c] ^ (m_s4[k][c] >> 13);
				nc[c] = mc[23:0];
			end
			n00_s5[k] <= nc[0];
			n01_s5[k] <= nc[2];
			pt_s5[k]  <= ($signed({1'b0, nc[1]}) - $signed({1'b0, nc[0]}))
				* $signed({1'b0, wx_s4[k]});
			pb_s5[k]  <= ($signed({1'b0, nc[3]}) - $signed({1'b0, nc[2]}))
				* $signed({1'b0, wx_s4[k]});
			wy_s5[k]  <= wy_s4[k];

			top_s6[k] <= n00_s5[k] + pt_s5[k][39:16];
			bot_s6[k] <= n01_s5[k] + pb_s5[k][39:16];
			wy_s6[k]  <= wy_s5[k];

			top_s7[k] <= top_s6[k];
			p2_s7[k]  <= ($signed({1'b0, bot_s6[k]}) - $signed({1'b0, top_s6[k]}))
				* $signed({1'b0, wy_s6[k]});

			dt = p2_s7[k][39:16];
			v_s8[k] <= top_s7[k] + dt;
		end

		sum = 26'(v_s8[0] >> 1) + 26'(v_s8[1] >> 2) + 26'(v_s8[2] >> 3)
			+ 26'(v_s8[3] >> 4);
		level_s9 <= (sum[25:24] != 2'b00) ? 16'hFFFF : sum[23:8];

		texel.red         <= mix8(clo_q[23:16], chi_q[23:16], level_s9);
		texel.green       <= mix8(clo_q[15:8], chi_q[15:8], level_s9);
		texel.blue        <= mix8(clo_q[7:0], chi_q[7:0], level_s9);
		texel.noise_level <= level_s9;
	end

	`ASSERT_SAME(a_latency, clk, arst_n, accept, ##LATENCY done, "texel lost in pipeline")
	`ASSERT_NEXT(a_valid_chain, clk, arst_n, vld[4], vld[5], "valid bit dropped")
	`ASSERT_NEXT(a_done_src, clk, arst_n, !vld[9], !done, "done without request")

endmodule

### bench/fvn_texel_checker.sv
// checker for the fractal value noise texel generator: predicts and compares texels
module fvn_texel_checker (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  logic            busy,
	input  fvn_pkg::pixel_t pixel,
	input  logic            cfg_valid,
	input  logic            cfg_ready,
	input  logic [fvn_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]     cfg_data,
	input  logic            done,
	input  fvn_pkg::texel_t texel,
	output int              fail_count,
	output int              pending
);
	timeunit 1ns;
	timeprecision 1ps;
	import fvn_pkg::*;

	localparam int MAX_S = 12;

	logic [3:0]  size_log2;
	logic [31:0] noise_seed;
	logic [23:0] color_low;
	logic [23:0] color_high;
	texel_t      texel_q[$];

	function automatic logic [23:0] lattice_hash(logic [31:0] cx, logic [31:0] cy,
		logic [31:0] seed);
		logic [31:0] h;
		h = seed;
		h ^= cx * HASH_X;
		h ^= cy * HASH_Y;
		h ^= h >> 15;
		h = h * HASH_MIX;
		h ^= h >> 13;
		return h[23:0];
	endfunction

	function automatic logic [63:0] smoothstep_q16(logic [63:0] f);
		return (f * f * (64'd12288 - 64'd2 * f)) >> 20;
	endfunction

	function automatic logic [63:0] lerp24(logic [63:0] a, logic [63:0] b, logic [63:0] w);
		return (a * (64'd65536 - w) + b * w) >> 16;
	endfunction

	function automatic logic [7:0] channel_mix(logic [7:0] lo, logic [7:0] hi,
		logic [15:0] lvl);
		logic [63:0] v;
		v = 64'(lo) * (64'd65536 - 64'(lvl)) + 64'(hi) * 64'(lvl) + 64'd32768;
		return v[23:16];
	endfunction

	function automatic texel_t noise_texel(pixel_t p);
		texel_t t;
		logic [63:0] x, y, wx, wy, top, bot, sum;
		logic [31:0] ix, iy, seed;
		int s, sh;
		s = (size_log2 > MAX_S) ? MAX_S : int'(size_log2);
		sum = 0;
		for (int k = 0; k < OCTAVES; k++) begin
			sh = 15 + k - s;
			seed = noise_seed + 32'(k);
			x = 64'(p.pixel_x) << sh;
			y = 64'(p.pixel_y) << sh;
			ix = x[43:12];
			iy = y[43:12];
			wx = smoothstep_q16(x & 64'hFFF);
			wy = smoothstep_q16(y & 64'hFFF);
			top = lerp24(lattice_hash(ix, iy, seed), lattice_hash(ix + 1, iy, seed), wx);
			bot = lerp24(lattice_hash(ix, iy + 1, seed), lattice_hash(ix + 1, iy + 1, seed), wx);
			sum += lerp24(top, bot, wy) >> (k + 1);
		end
		sum >>= 8;
		t.noise_level = (sum > 65535) ? 16'hFFFF : sum[15:0];
		t.red   = channel_mix(color_low[23:16], color_high[23:16], t.noise_level);
		t.green = channel_mix(color_low[15:8], color_high[15:8], t.noise_level);
		t.blue  = channel_mix(color_low[7:0], color_high[7:0], t.noise_level);
		return t;
	endfunction

	assign pending = texel_q.size();

	always @(posedge clk or negedge arst_n) begin
		texel_t e;
		int errs;
		if (!arst_n) begin
			size_log2  <= SIZE_RESET;
			noise_seed <= '0;
			color_low  <= '0;
			color_high <= COLOR_WHITE;
			fail_count <= 0;
			texel_q.delete();
		end else begin
			errs = 0;
			if (done) begin
				if (texel_q.size() == 0) begin
					$error("texel with no request pending: %h", texel);
					errs = errs + 1;
				end else begin
					e = texel_q.pop_front();
					if (e.red !== texel.red) begin
						$error("red expected %0d actual %0d", e.red, texel.red);
						errs = errs + 1;
					end
					if (e.green !== texel.green) begin
						$error("green expected %0d actual %0d", e.green, texel.green);
						errs = errs + 1;
					end
					if (e.blue !== texel.blue) begin
						$error("blue expected %0d actual %0d", e.blue, texel.blue);
						errs = errs + 1;
					end
					if (e.noise_level !== texel.noise_level) begin
						$error("noise_level expected %0d actual %0d", e.noise_level,
							texel.noise_level);
						errs = errs + 1;
					end
				end
			end
			fail_count <= fail_count + errs;
			if (start && !busy)
				texel_q.push_back(noise_texel(pixel));
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_SIZE_LOG2:  size_log2  <= cfg_data[3:0];
					REG_NOISE_SEED: noise_seed <= cfg_data;
					REG_COLOR_LOW:  color_low  <= cfg_data[23:0];
					REG_COLOR_HIGH: color_high <= cfg_data[23:0];
					default: ;
				endcase
			end
		end
	end
endmodule

### bench/tb_fractal_value_noise_texel.sv
// testbench top of the fractal value noise texel generator: stimulus and verdict
module tb_fractal_value_noise_texel;
	timeunit 1ns;
	timeprecision 1ps;
	import fvn_pkg::*;

	logic clk = 0;
	logic arst_n = 0;
	logic start = 0;
	logic busy;
	pixel_t pixel = '0;
	logic cfg_valid = 0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [31:0] cfg_data = '0;
	logic done;
	texel_t texel;
	int fail_count;
	int pending;
	logic [3:0] cur_size = SIZE_RESET;

	always #4 clk = ~clk;

	fractal_value_noise_texel u_dut (.*);

	fvn_texel_checker u_chk (.*);

	task automatic send_pixel(logic [11:0] px, logic [11:0] py, bit allow_gap);
		int gap;
		if (allow_gap && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 6);
			start <= 0;
			repeat (gap) @(negedge clk);
		end
		start <= 1;
		pixel <= '{pixel_x: px, pixel_y: py};
		@(posedge clk);
		while (busy) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic drain();
		start <= 0;
		while (pending != 0) @(negedge clk);
		repeat (12) @(negedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		@(negedge clk);
		cfg_valid <= 0;
		if (idx == REG_SIZE_LOG2)
			cur_size = data[3:0];
	endtask

	// coordinates mostly inside the edge, sometimes anywhere
	task automatic random_pixel(bit allow_gap);
		int lim;
		lim = (cur_size >= 12) ? 4095 : (1 << cur_size) - 1;
		if ($urandom_range(0, 4) == 0)
			send_pixel(12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)),
				allow_gap);
		else
			send_pixel(12'($urandom_range(0, lim)), 12'($urandom_range(0, lim)),
				allow_gap);
	endtask

	initial begin
		#2ms;
		$display("[fractal_value_noise_texel] ERROR");
		$finish;
	end

	initial begin
		static logic [3:0] sizes[8] = '{4'd0, 4'd1, 4'd3, 4'd8, 4'd12, 4'd15, 4'd5, 4'd13};
		repeat (2) @(negedge clk);
		arst_n = 1;
		@(negedge clk);
		send_pixel(0, 0, 0);
		send_pixel(255, 255, 0);
		send_pixel(4095, 4095, 0);
		send_pixel(4095, 0, 0);
		send_pixel(0, 4095, 0);
		send_pixel(12'hAAA, 12'h555, 0);
		send_pixel(12'h555, 12'hAAA, 0);
		drain();
		write_reg(REG_SIZE_LOG2, 4'd0);
		write_reg(REG_NOISE_SEED, 32'hFFFFFFFF);
		write_reg(REG_COLOR_LOW, 24'hFFFFFF);
		write_reg(REG_COLOR_HIGH, 24'h000000);
		write_reg(3'd6, 32'h12345678);
		send_pixel(0, 0, 0);
		send_pixel(1, 1, 0);
		send_pixel(4095, 4095, 0);
		drain();
		write_reg(REG_SIZE_LOG2, 4'd15);
		write_reg(REG_NOISE_SEED, 32'hFFFFFFFD);
		write_reg(REG_COLOR_LOW, 24'h0000FF);
		write_reg(REG_COLOR_HIGH, 24'hFF0000);
		send_pixel(0, 4095, 0);
		send_pixel(4095, 0, 0);
		send_pixel(2048, 2048, 0);
		send_pixel(123, 3999, 0);
		drain();
		for (int ph = 0; ph < 8; ph++) begin
			write_reg(REG_SIZE_LOG2, sizes[ph]);
			write_reg(REG_NOISE_SEED, $urandom());
			write_reg(REG_COLOR_LOW, $urandom_range(0, 24'hFFFFFF));
			write_reg(REG_COLOR_HIGH, $urandom_range(0, 24'hFFFFFF));
			for (int i = 0; i < 180; i++)
				random_pixel(ph < 7);
			drain();
		end
		if (fail_count == 0)
			$display("[fractal_value_noise_texel] OK");
		else
			$display("[fractal_value_noise_texel] ERROR");
		$finish;
	end
endmodule
